// ===== rtl/sla_pkg.sv =====
// Shared types and constants of the serial line assembler.
package sla_pkg;

  // Port numbers and buffer sizes.
  localparam int unsigned PORTS      = 4;
  localparam int unsigned PORT_W     = 2;
  localparam int unsigned LINE_BYTES = 512;
  localparam int unsigned LEN_W      = $clog2(LINE_BYTES);
  localparam int unsigned ROW_BYTES  = 8;
  localparam int unsigned LANE_W     = $clog2(ROW_BYTES);
  localparam int unsigned ROW_W      = $clog2(LINE_BYTES / ROW_BYTES);
  localparam int unsigned STORE_ROWS = PORTS * LINE_BYTES / ROW_BYTES;
  localparam int unsigned ADDR_W     = $clog2(STORE_ROWS);
  localparam int unsigned TAKE_W     = 4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Bus widths.
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Operations passed from the front to the back.
  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_LINE_END = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [PORT_W-1:0] port;
    logic [7:0]        data;
  } cmd_t;

endpackage

// ===== rtl/sla_front.sv =====
// Front end: holds the open mask, accepts words and classifies them into operations.
module sla_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [15:0]          s_axis_tdata_i,
  input  logic                 s_axis_tuser_i,
  output logic                 push_o,
  output sla_pkg::cmd_t        cmd_o,
  input  logic                 queue_ready_i
);
  import sla_pkg::*;

  logic [PORTS-1:0]  open_mask_q;
  logic [PORT_W-1:0] port;
  logic [7:0]        data;
  logic              keep;

  // Open mask register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_mask_q <= '0;
    end else if (cfg_we_i) begin
      open_mask_q <= cfg_wdata_i[PORTS-1:0];
    end
  end

  assign port = s_axis_tdata_i[PORT_W-1:0];
  assign data = s_axis_tdata_i[PORT_W+7:PORT_W];

  // Classify the word; dropped words are accepted but never queued.
  always_comb begin
    keep       = 1'b0;
    cmd_o.op   = OP_WRITE;
    cmd_o.port = port;
    cmd_o.data = data;
    if (s_axis_tuser_i) begin
      keep     = 1'b1;
      cmd_o.op = OP_CLEAR;
    end else if (open_mask_q[port]) begin
      if (data == CH_NEWLINE) begin
        keep     = 1'b1;
        cmd_o.op = OP_LINE_END;
      end else if (data != CH_RETURN) begin
        keep     = 1'b1;
        cmd_o.op = OP_WRITE;
      end
    end
  end

  assign s_axis_tready_o = queue_ready_i;
  assign push_o          = s_axis_tvalid_i && queue_ready_i && keep;

endmodule

// ===== rtl/sla_queue.sv =====
// Short queue of operations between the front and the back.
module sla_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sla_pkg::cmd_t cmd_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sla_pkg::cmd_t cmd_o
);
  import sla_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push;
  logic              do_pop;

  assign ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/sla_back.sv =====
// Back end: line store, per-port lengths and chunked emission of finished lines.
module sla_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  sla_pkg::cmd_t                cmd_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [sla_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);
  import sla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_e;

  state_e            state_q;
  logic [7:0]        line_mem [STORE_ROWS][ROW_BYTES];
  logic [7:0]        rd_row_q [ROW_BYTES];
  logic [LEN_W-1:0]  fill_q [PORTS];
  logic [LEN_W-1:0]  kept_q [PORTS];
  logic [PORT_W-1:0] em_port_q;
  logic [LEN_W-1:0]  em_len_q;
  logic [ROW_W-1:0]  em_row_q;
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic              out_last_q;

  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [LANE_W-1:0] wr_lane;
  logic [ADDR_W-1:0] rd_addr;
  logic [LEN_W-1:0]  cur_fill;
  logic [LEN_W-1:0]  remain;
  logic [TAKE_W-1:0] take;
  logic              is_last;
  logic [63:0]       chunk;
  logic              slot_free;

  assign pop_o     = (state_q == S_IDLE) && cmd_valid_i;
  assign cur_fill  = fill_q[cmd_i.port];
  assign mem_we    = pop_o && (cmd_i.op == OP_WRITE)
                     && (cur_fill < LEN_W'(LINE_BYTES - 1));
  assign wr_addr   = {cmd_i.port, cur_fill[LEN_W-1:LANE_W]};
  assign wr_lane   = cur_fill[LANE_W-1:0];
  assign rd_addr   = {em_port_q, em_row_q};
  assign slot_free = !out_valid_q || m_axis_tready_i;

  // Bytes still to go from the current row on, and the size of this chunk.
  always_comb begin
    remain  = em_len_q - {em_row_q, LANE_W'(0)};
    is_last = (remain <= LEN_W'(ROW_BYTES));
    take    = is_last ? remain[TAKE_W-1:0] : TAKE_W'(ROW_BYTES);
    for (int i = 0; i < ROW_BYTES; i++) begin
      chunk[8*i +: 8] = (TAKE_W'(i) < take) ? rd_row_q[i] : 8'h00;
    end
  end

  // Line store: one byte lane written, one row read a cycle in S_READ.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[wr_addr][wr_lane] <= cmd_i.data;
    end
    if (state_q == S_READ) begin
      rd_row_q <= line_mem[rd_addr];
    end
  end

  // Sequencer, per-port lengths and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      em_port_q   <= '0;
      em_len_q    <= '0;
      em_row_q    <= '0;
      for (int p = 0; p < PORTS; p++) begin
        fill_q[p] <= '0;
        kept_q[p] <= '0;
      end
    end else begin
      if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_WRITE: begin
                if (mem_we) begin
                  fill_q[cmd_i.port] <= cur_fill + LEN_W'(1);
                  if (cmd_i.data != CH_SPACE) begin
                    kept_q[cmd_i.port] <= cur_fill + LEN_W'(1);
                  end
                end
              end
              OP_CLEAR: begin
                fill_q[cmd_i.port] <= '0;
                kept_q[cmd_i.port] <= '0;
              end
              OP_LINE_END: begin
                fill_q[cmd_i.port] <= '0;
                kept_q[cmd_i.port] <= '0;
                if (kept_q[cmd_i.port] > LEN_W'(1)) begin
                  em_port_q <= cmd_i.port;
                  em_len_q  <= kept_q[cmd_i.port];
                  em_row_q  <= '0;
                  state_q   <= S_READ;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          state_q <= S_SEND;
        end
        S_SEND: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {1'b0, em_len_q, take, chunk, em_port_q};
            out_last_q  <= is_last;
            if (is_last) begin
              state_q <= S_IDLE;
            end else begin
              em_row_q <= em_row_q + ROW_W'(1);
              state_q  <= S_READ;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/serial_line_assembler_top.sv =====
// Top level of the serial line assembler: front end, operation queue and back end.
//
// Words carry a port number, a clear flag and a received byte. Bytes for closed
// ports and carriage returns are dropped in the front end, which takes a word in
// every cycle while the four-entry queue has room. The back end takes a stored
// byte, a clear or a short line in its idle state; a newline that ends a line of
// L trimmed bytes (L of 2 or more) gives ceil(L/8) chunks, each 8-byte chunk one
// read of the 64-bit line store row followed by a load of the output register.
// While a line is sent, the queue keeps taking words, so the input stalls only
// once it has filled. The line store needs no clearing after reset. The user must
// write open_mask through cfg_we_i while the block is idle, which is not enforced.
module serial_line_assembler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,     // open_mask, one bit per port
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // port [1:0], data [9:2], zeros [15:10]
  input  logic        s_axis_tuser_i,  // command: 1 clears the port's line
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,  // out_port [1:0], chunk [65:2],
                                       // chunk_bytes [69:66], line_length [78:70],
                                       // zero [79]
  output logic        m_axis_tlast_o   // last chunk of the line
);
  import sla_pkg::*;

  logic push;
  cmd_t front_cmd;
  logic queue_ready;
  logic pop;
  logic queue_valid;
  cmd_t queue_cmd;

  sla_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_o          (push),
    .cmd_o           (front_cmd),
    .queue_ready_i   (queue_ready)
  );

  sla_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .ready_o (queue_ready),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  sla_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (queue_valid),
    .cmd_i           (queue_cmd),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== test/serial_line_assembler_top_checker.sv =====
// Checker of the serial line assembler: predicts every output chunk and compares it.
`timescale 1ns / 100ps
module serial_line_assembler_top_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,  // port [1:0], data [9:2], zeros [15:10]
  input  logic        s_axis_tuser_i,  // command: 1 clears the port's line
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [79:0] m_axis_tdata_i,  // out_port [1:0], chunk [65:2],
                                       // chunk_bytes [69:66], line_length [78:70],
                                       // zero [79]
  input  logic        m_axis_tlast_i,
  output int unsigned mismatch_count_o,
  output int unsigned chunks_due_o,
  output int unsigned chunks_matched_o,
  output int unsigned lines_matched_o
);
  import sla_pkg::*;

  // One outgoing word as the block should send it.
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [63:0]       bytes;
    logic [TAKE_W-1:0] count;
    logic [LEN_W-1:0]  trim_len;
    logic              last;
  } line_chunk_t;

  // Predicted state: line buffers, lengths and the open ports.
  logic [7:0]       line_mem [PORTS][LINE_BYTES];
  int unsigned      fill_len [PORTS];
  int unsigned      kept_len [PORTS];
  logic [PORTS-1:0] open_mask;
  line_chunk_t      chunks_due [$];
  line_chunk_t      seen_chunk;
  line_chunk_t      due_chunk;
  int unsigned      port_idx;

  // Applies one accepted input word to the predicted state and queues the
  // chunks that a completed line gives.
  task automatic frame_word(input logic [PORT_W-1:0] p, input logic clear,
                            input logic [7:0] b);
    int unsigned pos;
    int unsigned take;
    int unsigned i;
    line_chunk_t c;
    if (clear) begin
      // A clear empties the buffer whether or not the port is open.
      fill_len[p] = 0;
      kept_len[p] = 0;
    end else if (open_mask[p]) begin
      if (b == CH_NEWLINE) begin
        // Lines of fewer than two kept bytes are dropped without a word.
        pos = 0;
        while (kept_len[p] > 1 && pos < kept_len[p]) begin
          take = (kept_len[p] - pos > ROW_BYTES) ? ROW_BYTES : kept_len[p] - pos;
          c.port  = p;
          c.bytes = '0;
          for (i = 0; i < take; i++) begin
            c.bytes[8*i +: 8] = line_mem[p][pos + i];
          end
          pos += take;
          c.count    = TAKE_W'(take);
          c.trim_len = LEN_W'(kept_len[p]);
          c.last     = (pos >= kept_len[p]);
          chunks_due.push_back(c);
        end
        fill_len[p] = 0;
        kept_len[p] = 0;
      end else if (b != CH_RETURN && fill_len[p] < LINE_BYTES - 1) begin
        // Trailing spaces are stored but do not move the kept length.
        line_mem[p][fill_len[p]] = b;
        fill_len[p]++;
        if (b != CH_SPACE) begin
          kept_len[p] = fill_len[p];
        end
      end
    end
  endtask

  // Watch both channels and the register write at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (port_idx = 0; port_idx < PORTS; port_idx++) begin
        fill_len[port_idx] = 0;
        kept_len[port_idx] = 0;
      end
      open_mask = '0;
      chunks_due.delete();
      mismatch_count_o = 0;
      chunks_matched_o = 0;
      lines_matched_o  = 0;
      chunks_due_o     = 0;
    end else begin
      if (cfg_we_i) begin
        open_mask = cfg_wdata_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        frame_word(s_axis_tdata_i[PORT_W-1:0], s_axis_tuser_i,
                   s_axis_tdata_i[PORT_W +: 8]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen_chunk.port     = m_axis_tdata_i[1:0];
        seen_chunk.bytes    = m_axis_tdata_i[65:2];
        seen_chunk.count    = m_axis_tdata_i[69:66];
        seen_chunk.trim_len = m_axis_tdata_i[78:70];
        seen_chunk.last     = m_axis_tlast_i;
        if (chunks_due.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected word: port %0d bytes %h count %0d length %0d last %0b",
                     $realtime, seen_chunk.port, seen_chunk.bytes, seen_chunk.count,
                     seen_chunk.trim_len, seen_chunk.last);
          end
          mismatch_count_o++;
        end else begin
          due_chunk = chunks_due.pop_front();
          if (seen_chunk !== due_chunk || m_axis_tdata_i[79] !== 1'b0) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: word mismatch", $realtime);
              $display("  expected port %0d bytes %h count %0d length %0d last %0b pad 0",
                       due_chunk.port, due_chunk.bytes, due_chunk.count,
                       due_chunk.trim_len, due_chunk.last);
              $display("  actual   port %0d bytes %h count %0d length %0d last %0b pad %0b",
                       seen_chunk.port, seen_chunk.bytes, seen_chunk.count,
                       seen_chunk.trim_len, seen_chunk.last, m_axis_tdata_i[79]);
            end
            mismatch_count_o++;
          end else begin
            chunks_matched_o++;
            if (seen_chunk.last) begin
              lines_matched_o++;
            end
          end
        end
      end
      chunks_due_o = chunks_due.size();
    end
  end

endmodule

// ===== test/serial_line_assembler_top_tb.sv =====
// Testbench top of the serial line assembler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module serial_line_assembler_top_tb;
  import sla_pkg::*;

  // Command flag carried in tuser.
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam int unsigned RANDOM_WORDS  = 350;
  localparam int unsigned SEGMENTS      = 7;
  localparam int unsigned IDLE_PCT      = 33;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CFG_PAUSE     = 4 * QUEUE_DEPTH + 4;
  // Allows for a full line in the back end, plus the queue.
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT   = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [79:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  int unsigned mismatch_count;
  int unsigned chunks_due;
  int unsigned chunks_matched;
  int unsigned lines_matched;

  // Stimulus bookkeeping.
  logic             calm;
  int unsigned      holds_asked;
  logic [PORTS-1:0] open_ports;
  int unsigned      words_sent;
  int unsigned      counted_words;
  int unsigned      settings_used;
  int unsigned      goal_len [PORTS];
  int unsigned      built_len [PORTS];
  int unsigned      cycle_count = 0;

  serial_line_assembler_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  serial_line_assembler_top_checker line_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tuser_i   (s_axis_tuser_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .m_axis_tlast_i   (m_axis_tlast_o),
    .mismatch_count_o (mismatch_count),
    .chunks_due_o     (chunks_due),
    .chunks_matched_o (chunks_matched),
    .lines_matched_o  (lines_matched)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words still due", cycle_count, chunks_due);
      $display("serial_line_assembler_top verification failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, a calm stretch and long hold-offs on request.
  initial begin
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served    = 0;
    hold_left       = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one word, with random gaps before it, and returns at the edge that
  // accepts it. tvalid stays high so that a following word goes back to back.
  task automatic send_word(input logic [PORT_W-1:0] p, input logic cmd, input logic [7:0] b);
    logic took;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, b, p};
    s_axis_tuser_i  <= cmd;
    do begin
      @(negedge clk_i);
      took = s_axis_tready_o;
      @(posedge clk_i);
    end while (!took);
    words_sent++;
  endtask

  // Waits until every predicted word has arrived and the queue has drained,
  // then writes open_mask.
  task automatic set_open_ports(input logic [PORTS-1:0] m);
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (chunks_due != 0);
    repeat (CFG_PAUSE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    open_ports  = m;
    settings_used++;
  endtask

  // A line byte: spaces and carriage returns now and then, never a newline.
  function automatic logic [7:0] line_char();
    int unsigned roll;
    logic [7:0]  v;
    roll = $urandom_range(99);
    if (roll < 12) begin
      return CH_SPACE;
    end
    if (roll < 16) begin
      return CH_RETURN;
    end
    do v = 8'($urandom_range(255)); while (v == CH_NEWLINE);
    return v;
  endfunction

  // One random word. Most build well-formed lines on open ports; the rest are
  // clears, raw bytes and words for closed ports.
  task automatic random_word(input int unsigned longest);
    logic [PORT_W-1:0] p;
    int unsigned       roll;
    roll = $urandom_range(99);
    p    = PORT_W'($urandom_range(PORTS - 1));
    if (roll >= 10) begin
      while (!open_ports[p]) p = PORT_W'($urandom_range(PORTS - 1));
    end
    if (roll < 5) begin
      send_word(p, CMD_CLEAR, 8'($urandom_range(255)));
      built_len[p] = 0;
    end else if (roll < 8) begin
      send_word(p, CMD_DATA, 8'($urandom_range(255)));
    end else if (built_len[p] >= goal_len[p]) begin
      send_word(p, CMD_DATA, CH_NEWLINE);
      built_len[p] = 0;
      goal_len[p]  = ($urandom_range(9) == 0) ? $urandom_range(longest) : $urandom_range(20);
    end else begin
      send_word(p, CMD_DATA, line_char());
      built_len[p]++;
    end
    if (open_ports[p] || roll < 5) begin
      counted_words++;
    end
  endtask

  // Main stimulus.
  initial begin
    int unsigned      seg;
    int unsigned      seg_end;
    int unsigned      i;
    logic [PORT_W-1:0] long_port;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_DATA;
    calm            = 1'b0;
    holds_asked     = 0;
    open_ports      = '0;
    words_sent      = 0;
    counted_words   = 0;
    settings_used   = 0;
    for (i = 0; i < PORTS; i++) begin
      goal_len[i]  = $urandom_range(20);
      built_len[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with every port open: extreme byte values, a skipped
    // return, trailing spaces, a short line, an empty line, a clear mid-line
    // and a line of the shortest length that is sent.
    set_open_ports(4'hF);
    send_word(2'd0, CMD_DATA, 8'h00);
    send_word(2'd0, CMD_DATA, 8'hFF);
    send_word(2'd0, CMD_DATA, 8'h41);
    send_word(2'd0, CMD_DATA, CH_RETURN);
    send_word(2'd0, CMD_DATA, CH_SPACE);
    send_word(2'd0, CMD_DATA, 8'h42);
    send_word(2'd0, CMD_DATA, CH_SPACE);
    send_word(2'd0, CMD_DATA, CH_SPACE);
    send_word(2'd0, CMD_DATA, CH_NEWLINE);
    send_word(2'd1, CMD_DATA, 8'h78);
    send_word(2'd1, CMD_DATA, CH_NEWLINE);
    send_word(2'd1, CMD_DATA, 8'h7A);
    send_word(2'd1, CMD_DATA, 8'h7A);
    send_word(2'd2, CMD_DATA, CH_NEWLINE);
    send_word(2'd3, CMD_DATA, 8'h71);
    send_word(2'd3, CMD_CLEAR, 8'hA5);
    send_word(2'd3, CMD_DATA, 8'h6B);
    send_word(2'd3, CMD_DATA, 8'h6B);
    send_word(2'd3, CMD_DATA, CH_NEWLINE);

    // Port 1 closed: its data is ignored but a clear still empties it.
    set_open_ports(4'b0101);
    send_word(2'd1, CMD_CLEAR, 8'h5A);
    send_word(2'd1, CMD_DATA, 8'h77);
    send_word(2'd1, CMD_DATA, CH_NEWLINE);

    // Every port closed: nothing is stored.
    set_open_ports(4'h0);
    for (i = 0; i < 6; i++) begin
      send_word(PORT_W'($urandom_range(PORTS - 1)), CMD_DATA,
                ($urandom_range(1) == 0) ? CH_NEWLINE : 8'($urandom_range(255)));
    end

    // Random part in segments, each under its own set of open ports.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 0 || seg == 4) begin
        set_open_ports(4'hF);
      end else begin
        set_open_ports(PORTS'($urandom_range(1, 15)));
      end
      calm = (seg == 1);
      if (seg == 0) begin
        // One overlong line: the buffer fills, later bytes are dropped and the
        // line goes out at the greatest length.
        long_port = PORT_W'($urandom_range(PORTS - 1));
        send_word(long_port, CMD_CLEAR, 8'($urandom_range(255)));
        for (i = 0; i < LINE_BYTES + 8; i++) begin
          send_word(long_port, CMD_DATA, 8'($urandom_range(8'h21, 8'hFF)));
        end
        send_word(long_port, CMD_DATA, CH_NEWLINE);
        built_len[long_port] = 0;
      end
      if (seg == 2) begin
        holds_asked++;
      end
      seg_end = counted_words + RANDOM_WORDS / SEGMENTS;
      while (counted_words < seg_end) begin
        random_word((seg == 2) ? 60 : 40);
      end
    end
    calm = 1'b0;

    // Drain and give the verdict.
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (chunks_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d input words under %0d open-port settings, one overlong line included,",
             words_sent, settings_used);
    $display("with a %0d-cycle output hold-off; %0d words of %0d lines matched, %0d mismatched.",
             HOLD_CYCLES, chunks_matched, lines_matched, mismatch_count);
    if (mismatch_count == 0) begin
      $display("serial_line_assembler_top verification clean");
    end else begin
      $display("serial_line_assembler_top verification failed");
    end
    $finish;
  end

endmodule
